@@ design/stpg_pkg.sv @@
// ----------------------------------------------------------------------------
// stpg_pkg
// Shared constants, types and helpers of the square tone preview generator.
// ----------------------------------------------------------------------------
package stpg_pkg;

  localparam int PHASE_BITS  = 24;
  localparam int MAX_SAMPLES = 64;
  localparam int MIN_SAMPLES = 8;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  localparam int REG_W     = 8;
  localparam int RATE_W    = 18;
  localparam int FREQ_W    = 11;
  localparam int D_W       = FREQ_W + 1;
  localparam int DIV_W     = D_W + RATE_W;
  localparam int QUOT_W    = 17 + PHASE_BITS + 1;
  localparam int QCNT_W    = $clog2(QUOT_W);
  localparam int AMP_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int IN_DATA_W = 80;
  localparam int CFG_DW    = 18;
  localparam int CFG_AW    = 1;

  localparam logic [D_W-1:0]    D_FULL   = D_W'(2048);
  localparam logic [D_W-1:0]    D_MIN    = D_W'(32);
  localparam logic [AMP_W-1:0]  AMP_MAX  = AMP_W'(28000);
  localparam logic [REG_W-1:0]  MV_MASK  = 8'h77;
  localparam logic [REG_W-1:0]  RT_MASK  = 8'h11;
  localparam logic [REG_W-1:0]  PW_SOUND = 8'h80;

  localparam logic [PHASE_BITS-1:0] STEP_LO = PHASE_BITS'(64'd1 << (PHASE_BITS - 12));
  localparam logic [PHASE_BITS-1:0] STEP_HI = PHASE_BITS'((64'd9 << PHASE_BITS) / 64'd20);

  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(64);
  localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(48000);

  localparam logic [CFG_AW-1:0] REG_SAMPLE_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] REG_DEFAULT_RATE = 1'd1;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  function automatic logic [PHASE_BITS-1:0] duty_thresh(input logic [1:0] sel);
    logic [PHASE_BITS:0] one;
    logic [PHASE_BITS:0] val;
    begin
      one = (PHASE_BITS + 1)'(1) << PHASE_BITS;
      case (sel)
        2'd0:    val = one >> 3;
        2'd1:    val = one >> 2;
        2'd2:    val = one >> 1;
        default: val = (one >> 1) + (one >> 2);
      endcase
      return val[PHASE_BITS-1:0];
    end
  endfunction

endpackage

@@ design/stpg_div.sv @@
// ----------------------------------------------------------------------------
// stpg_div
// Bit-serial restoring divider: 2^(QUOT_W-1) / divisor, one quotient bit
// per cycle through one shared subtract and compare.
// ----------------------------------------------------------------------------
module stpg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stpg_pkg::DIV_W-1:0]  divisor,
  output stpg_pkg::div_res_t          res
);
  import stpg_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;

  logic [DIV_W:0]    rem_sh;
  logic [DIV_W+1:0]  diff;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, (cnt_r == QCNT_W'(QUOT_W - 1))};
    diff   = {1'b0, rem_sh} - {2'b00, div_r};
    fits   = !diff[DIV_W+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QCNT_W'(QUOT_W - 1);
      div_nxt  = divisor;
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quot_nxt = {quot_r[QUOT_W-2:0], fits};
      cnt_nxt  = cnt_r - QCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

@@ design/square_tone_preview_generator_unit.sv @@
// ----------------------------------------------------------------------------
// square_tone_preview_generator_unit
// Pulse-wave preview of sound channel one from a register snapshot.
//
// Input words carry a snapshot of the channel-one registers and a sample
// rate; each accepted word yields a run of sample_count (clamped to 8..64)
// signed samples on the output channel, tlast set on the final sample of the run.
// An audible word first computes the phase step in a bit-serial divider,
// then emits one sample per cycle while the receiver takes them. A muted
// word skips the divider and emits its zeros at once.
// in_tready is high only while no word is in work; the last sample of a run
// may still wait in the output register while the next word is taken.
// A stalled receiver holds the output register and pauses the run.
// Reset clears the phase accumulator, sample_count to 64 and default_rate
// to 48000. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module square_tone_preview_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // duty_length_reg[7:0], envelope_reg[15:8], freq_low_reg[23:16],
  // freq_high_reg[31:24], master_volume_reg[39:32], routing_reg[47:40],
  // power_reg[55:48], rate_hz[73:56], zero fill above
  input  logic [stpg_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample_value[15:0]
  output logic [stpg_pkg::SAMPLE_W-1:0]   out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [stpg_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [stpg_pkg::CFG_DW-1:0]     cfg_wdata
);
  import stpg_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      cfg_count_r;
  logic [RATE_W-1:0]     cfg_rate_r;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] step_r, step_nxt;
  logic [PHASE_BITS-1:0] duty_r, duty_nxt;
  logic [AMP_W-1:0]      amp_r, amp_nxt;
  logic                  gated_r, gated_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [SAMPLE_W-1:0]   odata_r, odata_nxt;
  logic                  olast_r, olast_nxt;

  logic [REG_W-1:0]  duty_reg, env_reg, flo_reg, fhi_reg, mv_reg, rt_reg, pw_reg;
  logic [RATE_W-1:0] rate_in, rate_sel;
  logic [D_W-1:0]    d_raw, d_val;
  logic [DIV_W-1:0]  divisor;
  logic [4:0]        mix_sum;
  logic [7:0]        vm;
  logic [AMP_W-1:0]  amp_raw;
  logic              audible, accept, div_start, load, last_smp;
  logic [CNT_W-1:0]  count_clamp;
  logic [QUOT_W-1:0] quot;
  div_res_t          div_res;

  assign duty_reg = in_tdata[7:0];
  assign env_reg  = in_tdata[15:8];
  assign flo_reg  = in_tdata[23:16];
  assign fhi_reg  = in_tdata[31:24];
  assign mv_reg   = in_tdata[39:32];
  assign rt_reg   = in_tdata[47:40];
  assign pw_reg   = in_tdata[55:48];
  assign rate_in  = in_tdata[73:56];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    audible = ((pw_reg & PW_SOUND) != '0) && (pw_reg[0] || fhi_reg[7]) &&
              ((mv_reg & MV_MASK) != '0) && ((rt_reg & RT_MASK) != '0) &&
              (env_reg[7:4] != 4'd0);
    rate_sel = (rate_in != '0) ? rate_in :
               (cfg_rate_r != '0) ? cfg_rate_r : RATE_W'(1);
    d_raw    = D_FULL - {1'b0, fhi_reg[2:0], flo_reg};
    d_val    = (d_raw < D_MIN) ? D_MIN : d_raw;
    divisor  = DIV_W'(d_val) * DIV_W'(rate_sel);
    mix_sum  = 5'(mv_reg[6:4]) + 5'(mv_reg[2:0]) + 5'd2;
    vm       = 8'(env_reg[7:4]) * 8'(mix_sum[4:1]);
    amp_raw  = AMP_W'({vm, 7'd0}) + AMP_W'({vm, 6'd0});
    count_clamp = (cfg_count_r < CNT_W'(MIN_SAMPLES)) ? CNT_W'(MIN_SAMPLES) :
                  (cfg_count_r > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) :
                  cfg_count_r;
  end

  assign div_start = accept && audible;

  stpg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (divisor),
    .res     (div_res)
  );

  assign quot     = div_res.quot;
  assign load     = (state_r == ST_EMIT) && (!ovalid_r || out_tready);
  assign last_smp = (cnt_r == count_r - CNT_W'(1));

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    duty_nxt   = duty_r;
    amp_nxt    = amp_r;
    gated_nxt  = gated_r;
    count_nxt  = count_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          gated_nxt = !audible;
          count_nxt = count_clamp;
          cnt_nxt   = '0;
          duty_nxt  = duty_thresh(duty_reg[7:6]);
          amp_nxt   = (amp_raw > AMP_MAX) ? AMP_MAX : amp_raw;
          state_nxt = audible ? ST_DIVIDE : ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        if (div_res.done) begin
          if (quot < QUOT_W'(STEP_LO)) step_nxt = STEP_LO;
          else if (quot > QUOT_W'(STEP_HI)) step_nxt = STEP_HI;
          else step_nxt = quot[PHASE_BITS-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = last_smp;
          if (gated_r) begin
            odata_nxt = '0;
          end else begin
            odata_nxt = (phase_r < duty_r) ? {1'b0, amp_r} : -{1'b0, amp_r};
            phase_nxt = phase_r + step_r;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last_smp) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      ovalid_r    <= 1'b0;
      cfg_count_r <= COUNT_RST;
      cfg_rate_r  <= RATE_RST;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SAMPLE_COUNT: cfg_count_r <= cfg_wdata[CNT_W-1:0];
          REG_DEFAULT_RATE: cfg_rate_r  <= cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end
    end
    step_r  <= step_nxt;
    duty_r  <= duty_nxt;
    amp_r   <= amp_nxt;
    gated_r <= gated_nxt;
    count_r <= count_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  a_gated_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && gated_r) |=> $stable(phase_r))
    else $error("phase moved during a muted run");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIVIDE))
    else $error("divider finished outside the divide state");

  a_step_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !gated_r) |-> (step_r >= STEP_LO && step_r <= STEP_HI))
    else $error("phase step out of bounds");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r < count_r))
    else $error("sample counter overran the run length");

endmodule
